FILE: hdl/subtitle_row_transition_detector_macros.svh
// Assertion macros used by the subtitle row transition detector checker.
`ifndef SUBTITLE_ROW_TRANSITION_DETECTOR_MACROS_SVH
`define SUBTITLE_ROW_TRANSITION_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SRTD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SRTD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/srtd_pkg.sv
// Package with the types and constants of the subtitle row transition detector.
`timescale 1ns / 1ps

package srtd_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int POS_W  = 12;
	localparam int SIZE_W = 13;
	localparam int PIX_W  = 8;
	localparam int CNT_W  = 12;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Division by three as multiply and shift, exact for sizes up to 4096.
	localparam int DIV3_MUL_W = 12;
	localparam int DIV3_SHIFT = 13;
	localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 12'd2731;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd960;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd540;
	localparam logic [PIX_W-1:0]  LEVEL_RESET  = 8'd170;
	localparam logic [CNT_W-1:0]  LIMIT_RESET  = 12'd15;
	localparam logic [CNT_W-1:0]  MINRUN_RESET = 12'd5;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH      = 3'd0,
		REG_FRAME_HEIGHT     = 3'd1,
		REG_BINARIZE_LEVEL   = 3'd2,
		REG_TRANSITION_LIMIT = 3'd3,
		REG_MIN_RUN_ROWS     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [SIZE_W-1:0] frame_width;
		logic [SIZE_W-1:0] frame_height;
		logic [PIX_W-1:0]  binarize_level;
		logic [CNT_W-1:0]  transition_limit;
		logic [CNT_W-1:0]  min_run_rows;
	} cfg_t;

endpackage

FILE: hdl/srtd_if.sv
// Valid/ready stream interfaces for pixel requests and row results.
`timescale 1ns / 1ps

interface srtd_pix_if import srtd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] gray_pixel;

	modport source (output valid, output gray_pixel, input ready);
	modport sink (input valid, input gray_pixel, output ready);
endinterface

interface srtd_res_if import srtd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] row_transitions;
	logic [POS_W-1:0] row_number;
	logic             subtitle_found;
	logic             frame_end;

	modport source (output valid, output row_transitions, output row_number,
		output subtitle_found, output frame_end, input ready);
	modport sink (input valid, input row_transitions, input row_number,
		input subtitle_found, input frame_end, output ready);
endinterface

FILE: hdl/srtd_cfg_regs.sv
// APB-style configuration register file of the subtitle row transition detector.
`timescale 1ns / 1ps

module srtd_cfg_regs import srtd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width      <= WIDTH_RESET;
			cfg_q.frame_height     <= HEIGHT_RESET;
			cfg_q.binarize_level   <= LEVEL_RESET;
			cfg_q.transition_limit <= LIMIT_RESET;
			cfg_q.min_run_rows     <= MINRUN_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_FRAME_WIDTH:      cfg_q.frame_width      <= pwdata[SIZE_W-1:0];
				REG_FRAME_HEIGHT:     cfg_q.frame_height     <= pwdata[SIZE_W-1:0];
				REG_BINARIZE_LEVEL:   cfg_q.binarize_level   <= pwdata[PIX_W-1:0];
				REG_TRANSITION_LIMIT: cfg_q.transition_limit <= pwdata[CNT_W-1:0];
				REG_MIN_RUN_ROWS:     cfg_q.min_run_rows     <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_FRAME_WIDTH:      prdata = DATA_W'(cfg_q.frame_width);
			REG_FRAME_HEIGHT:     prdata = DATA_W'(cfg_q.frame_height);
			REG_BINARIZE_LEVEL:   prdata = DATA_W'(cfg_q.binarize_level);
			REG_TRANSITION_LIMIT: prdata = DATA_W'(cfg_q.transition_limit);
			REG_MIN_RUN_ROWS:     prdata = DATA_W'(cfg_q.min_run_rows);
			default:              prdata = '0;
		endcase
	end

endmodule

FILE: hdl/subtitle_row_transition_detector.sv
// Top level of the subtitle row transition detector.
`timescale 1ns / 1ps
// A row result is registered and shown in the cycle after the request of the row's last pixel.
// Throughput: one pixel request per cycle; the only stall is a row's last pixel arriving
// while the previous row result is still untaken.
// Per pixel, one compare, one range check and one increment sit between state registers.
// Reset (arst_n, asynchronous, active low) clears positions, counts, flag and result valid,
// and loads the register defaults 960 x 540, level 170, limit 15, minimum run 5.

module subtitle_row_transition_detector import srtd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	srtd_pix_if.sink          pix_in,
	srtd_res_if.source        res_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t cfg;

	srtd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Frame state.
	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic             prev_bin_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] run_q;
	logic             flag_q;

	// Result register; it lets the next row's pixels flow while a result waits.
	logic             res_valid_q;
	logic [CNT_W-1:0] res_cnt_q;
	logic [POS_W-1:0] res_row_q;
	logic             res_flag_q;
	logic             res_end_q;

	logic [SIZE_W-1:0] w_eff;
	logic [SIZE_W-1:0] h_eff;
	logic [SIZE_W+DIV3_MUL_W-1:0] div3_prod;
	logic [POS_W-1:0]  start_col;
	logic [SIZE_W-1:0] stop_col;
	logic [SIZE_W-1:0] col_ext;
	logic [SIZE_W:0]   row_ext;
	logic              bin;
	logic              in_pair;
	logic [CNT_W-1:0]  cnt_new;
	logic              row_end;
	logic              last_row;
	logic              judged;
	logic [CNT_W-1:0]  run_new;
	logic              flag_new;
	logic              accept;

	// Out-of-range sizes are pinned: zero reads as one, anything larger as the maximum.
	always_comb begin
		w_eff = cfg.frame_width;
		if (cfg.frame_width == '0)
			w_eff = SIZE_W'(1);
		else if (cfg.frame_width > SIZE_W'(MAX_WIDTH))
			w_eff = SIZE_W'(MAX_WIDTH);
		h_eff = cfg.frame_height;
		if (cfg.frame_height == '0)
			h_eff = SIZE_W'(1);
		else if (cfg.frame_height > SIZE_W'(MAX_HEIGHT))
			h_eff = SIZE_W'(MAX_HEIGHT);
	end

	// The middle third starts at width/3; the reciprocal multiply gives the exact floor.
	assign div3_prod = (SIZE_W+DIV3_MUL_W)'(w_eff) * (SIZE_W+DIV3_MUL_W)'(DIV3_MUL);
	assign start_col = div3_prod[DIV3_SHIFT +: POS_W];
	assign stop_col  = w_eff - {1'b0, start_col};

	assign col_ext = {1'b0, col_q};
	assign row_ext = {2'b00, row_q};

	// Only a pixel that ends a row needs the result register, so the input is held
	// off just when such a pixel meets a result the sink has not yet taken.
	assign accept       = pix_in.valid && pix_in.ready;
	assign pix_in.ready = !res_valid_q || res_out.ready || !row_end;

	// The pair ending at the current column counts when start < column < stop.
	always_comb begin
		bin     = pix_in.gray_pixel > cfg.binarize_level;
		in_pair = (col_ext > {1'b0, start_col}) && (col_ext < stop_col);
		cnt_new = cnt_q;
		if (in_pair && (bin != prev_bin_q) && (cnt_q != CNT_MAX))
			cnt_new = cnt_q + CNT_W'(1);

		// A column or row at or past the end also closes it, which covers a size
		// shrunk between frames.
		row_end  = (col_ext + SIZE_W'(1)) >= w_eff;
		last_row = (row_ext + (SIZE_W+1)'(1)) >= {1'b0, h_eff};
		judged   = (row_q >= POS_W'(2)) && ((row_ext + (SIZE_W+1)'(3)) <= {1'b0, h_eff});

		// Run tracking: text rows extend the run, any other judged row closes it.
		run_new  = run_q;
		flag_new = flag_q;
		if (judged) begin
			if (cnt_new > cfg.transition_limit) begin
				if (run_q != CNT_MAX)
					run_new = run_q + CNT_W'(1);
			end else begin
				if (run_q >= cfg.min_run_rows)
					flag_new = 1'b1;
				run_new = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			prev_bin_q <= 1'b0;
			cnt_q      <= '0;
			run_q      <= '0;
			flag_q     <= 1'b0;
		end else if (accept) begin
			if (row_end) begin
				col_q      <= '0;
				cnt_q      <= '0;
				prev_bin_q <= 1'b0;
				if (last_row) begin
					row_q  <= '0;
					run_q  <= '0;
					flag_q <= 1'b0;
				end else begin
					row_q  <= row_q + POS_W'(1);
					run_q  <= run_new;
					flag_q <= flag_new;
				end
			end else begin
				col_q      <= col_q + POS_W'(1);
				cnt_q      <= cnt_new;
				prev_bin_q <= bin;
			end
		end
	end

	// Result valid: set by a row's last pixel, cleared once the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && row_end) begin
			res_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && row_end) begin
			res_cnt_q  <= cnt_new;
			res_row_q  <= row_q;
			res_flag_q <= flag_new;
			res_end_q  <= last_row;
		end
	end

	assign res_out.valid           = res_valid_q;
	assign res_out.row_transitions = res_cnt_q;
	assign res_out.row_number      = res_row_q;
	assign res_out.subtitle_found  = res_flag_q;
	assign res_out.frame_end       = res_end_q;

endmodule

FILE: hdl/srtd_checker.sv
// Port-level checker of the subtitle row transition detector and its bind.
`timescale 1ns / 1ps
`include "subtitle_row_transition_detector_macros.svh"

module srtd_checker import srtd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             pix_valid,
	input logic             pix_ready,
	input logic             res_valid,
	input logic             res_ready,
	input logic [CNT_W-1:0] res_transitions,
	input logic [POS_W-1:0] res_row,
	input logic             res_found,
	input logic             res_end
);

	// A result the sink holds off must stay put.
	`SRTD_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_transitions) && $stable(res_row) && $stable(res_found) && $stable(res_end), "stalled result changed")

	// With no result waiting, pixel requests are always taken.
	`SRTD_ASSERT_IMP(a_idle_ready, !res_valid, pix_ready, "pixel refused with no result waiting")

	// A new result only follows an accepted pixel request.
	`SRTD_ASSERT_IMP(a_res_cause, $rose(res_valid), $past(pix_valid && pix_ready), "result without a pixel request")

	// The first two rows of a frame are never judged, so the flag is still clear there.
	`SRTD_ASSERT_IMP(a_early_flag, res_valid && (res_row < POS_W'(2)), !res_found, "flag set before any judged row")

endmodule

bind subtitle_row_transition_detector srtd_checker u_srtd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.pix_valid       (pix_in.valid),
	.pix_ready       (pix_in.ready),
	.res_valid       (res_out.valid),
	.res_ready       (res_out.ready),
	.res_transitions (res_out.row_transitions),
	.res_row         (res_out.row_number),
	.res_found       (res_out.subtitle_found),
	.res_end         (res_out.frame_end)
);
